### hdl/pgd_pkg.sv
// ----------------------------------------------------------------------------
// pgd_pkg
// Shared constants, codes and arithmetic helpers of the pheromone grid unit.
// ----------------------------------------------------------------------------
package pgd_pkg;

  // default grid storage size
  localparam int DEFAULT_MAX_COLUMNS = 64;
  localparam int DEFAULT_MAX_ROWS    = 64;

  // width of the grid size registers and of a coordinate inside the grid
  localparam int SZW = 7;

  // dividend width of the shared divider (diffusion amount is below 2**39)
  localparam int DIVW = 39;
  localparam int DCW  = $clog2(DIVW);

  // configuration port address width and register indexes
  localparam int PAW = 5;
  localparam logic [2:0] REG_GRID_WIDTH   = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_WRAP_EDGES   = 3'd2;
  localparam logic [2:0] REG_DIFF_COEF    = 3'd3;
  localparam logic [2:0] REG_EVAP_COEF    = 3'd4;
  localparam logic [2:0] REG_MIN_LEVEL    = 3'd5;
  localparam logic [2:0] REG_DEFAULT_LVL  = 3'd6;

  // operation codes
  localparam logic [1:0] MODE_FILL  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  // neighbor offset codes
  localparam logic [1:0] OFF_NEG  = 2'd0;
  localparam logic [1:0] OFF_ZERO = 2'd1;
  localparam logic [1:0] OFF_POS  = 2'd2;

  // index of the cell itself after its eight neighbors
  localparam logic [3:0] NB_SELF = 4'd8;

  localparam logic signed [41:0] SAT_HI = 42'sd2147483647;
  localparam logic signed [41:0] SAT_LO = -42'sd2147483648;

  // saturate a wide signed sum to q16.16
  function automatic logic [31:0] sat_q(input logic signed [41:0] s);
    logic [31:0] r;
    if (s > SAT_HI) begin
      r = 32'h7fff_ffff;
    end else if (s < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // column offset of neighbor o, rows outer and columns inner
  function automatic logic [1:0] nb_dx(input logic [3:0] o);
    logic [1:0] r;
    case (o) inside
      4'd0, 4'd3, 4'd5: r = OFF_NEG;
      4'd1, 4'd6:       r = OFF_ZERO;
      default:          r = OFF_POS;
    endcase
    return r;
  endfunction

  // row offset of neighbor o
  function automatic logic [1:0] nb_dy(input logic [3:0] o);
    logic [1:0] r;
    case (o) inside
      4'd0, 4'd1, 4'd2: r = OFF_NEG;
      4'd3, 4'd4:       r = OFF_ZERO;
      default:          r = OFF_POS;
    endcase
    return r;
  endfunction

  // place a rounded coordinate: torus from the remainder, else clamp
  function automatic logic [SZW-1:0] place(input logic [16:0]    mag,
                                           input logic           neg,
                                           input logic [SZW-1:0] rem,
                                           input logic [SZW-1:0] size,
                                           input logic           wrap);
    logic [SZW-1:0] r;
    if (wrap) begin
      r = (neg && rem != '0) ? size - rem : rem;
    end else if (neg) begin
      r = '0;
    end else if (mag >= {{(17-SZW){1'b0}}, size}) begin
      r = size - 1'b1;
    end else begin
      r = mag[SZW-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/pheromone_grid_diffusion_unit.sv
// ----------------------------------------------------------------------------
// pheromone_grid_diffusion_unit
// One grid of signed q16.16 levels with fill, cell write, cell read and a
// tick of 8-neighbor diffusion followed by evaporation.
// ----------------------------------------------------------------------------
//  channel   signals                                      direction
//  request   start, busy, mode, x_pos, y_pos, level_in,   in (start when !busy)
//            time_step
//  result    done, level_out, done_mode                   out, one cycle each
//  config    psel, penable, pwrite, paddr, pwdata,        apb slave
//            prdata, pready
//
//  after reset a clearing pass zeroes the level memory with busy high;
//  config writes are taken meanwhile. write and read first run two passes
//  of the shared divider for the torus remainders. a tick runs up to three
//  sweeps (copy, copy back, evaporation): the copies with a nonzero
//  diffusion coefficient, evaporation with a nonzero evaporation
//  coefficient. between the copies each positive cell with neighbors takes
//  a divider pass and one scratch RAM read-modify-write per neighbor and
//  for itself. one request at a time; results cannot be stalled.
// ----------------------------------------------------------------------------
module pheromone_grid_diffusion_unit #(
  parameter int MAX_COLUMNS = pgd_pkg::DEFAULT_MAX_COLUMNS,
  parameter int MAX_ROWS    = pgd_pkg::DEFAULT_MAX_ROWS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode,
  input  logic signed [23:0]       x_pos,
  input  logic signed [23:0]       y_pos,
  input  logic signed [31:0]       level_in,
  input  logic [15:0]              time_step,
  output logic                     done,
  output logic signed [31:0]       level_out,
  output logic [1:0]               done_mode,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [pgd_pkg::PAW-1:0]  paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SZW   = pgd_pkg::SZW;
  localparam int DIVW  = pgd_pkg::DIVW;
  localparam int DCW   = pgd_pkg::DCW;

  // state codes
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLEAR  = 5'd1;
  localparam logic [4:0] S_FILL   = 5'd2;
  localparam logic [4:0] S_XDIV   = 5'd3;
  localparam logic [4:0] S_XFIX   = 5'd4;
  localparam logic [4:0] S_YDIV   = 5'd5;
  localparam logic [4:0] S_YFIX   = 5'd6;
  localparam logic [4:0] S_CELL   = 5'd7;
  localparam logic [4:0] S_CDATA  = 5'd8;
  localparam logic [4:0] S_TSTART = 5'd9;
  localparam logic [4:0] S_SWEEP  = 5'd10;
  localparam logic [4:0] S_DRAIN  = 5'd11;
  localparam logic [4:0] S_DRD    = 5'd12;
  localparam logic [4:0] S_DDATA  = 5'd13;
  localparam logic [4:0] S_DAMT   = 5'd14;
  localparam logic [4:0] S_DDIV   = 5'd15;
  localparam logic [4:0] S_NRD    = 5'd16;
  localparam logic [4:0] S_NWR    = 5'd17;
  localparam logic [4:0] S_FINISH = 5'd18;

  // sweep kinds
  localparam logic [1:0] SW_COPY = 2'd0;
  localparam logic [1:0] SW_BACK = 2'd1;
  localparam logic [1:0] SW_EVAP = 2'd2;

  // configuration registers
  logic [SZW-1:0]     grid_width;
  logic [SZW-1:0]     grid_height;
  logic               wrap_edges;
  logic [15:0]        diffusion_coef;
  logic [15:0]        evaporation_coef;
  logic [31:0]        min_level;
  logic [31:0]        default_level;

  // control and datapath registers
  logic [4:0]         state;
  logic [1:0]         mode_r;
  logic [31:0]        lvl_in_r;
  logic [15:0]        dt_r;
  logic [16:0]        x_mag;
  logic [16:0]        y_mag;
  logic               x_neg;
  logic               y_neg;
  logic [SZW-1:0]     cx;
  logic [SZW-1:0]     cy;
  logic [SZW-1:0]     x_cnt;
  logic [SZW-1:0]     y_cnt;
  logic [AW-1:0]      lin_cnt;
  logic [SZW-1:0]     div_rem;
  logic [DIVW-1:0]    div_quo;
  logic [SZW-1:0]     div_den;
  logic [DCW-1:0]     div_cnt;
  logic [31:0]        cd_diff;
  logic [31:0]        cd_evap;
  logic [63:0]        dprod;
  logic [DIVW-1:0]    amount;
  logic [3:0]         nb_cnt;
  logic [AW-1:0]      tgt_addr;
  logic [1:0]         sw_kind;
  logic               drain_cnt;
  logic               p1_vld;
  logic [AW-1:0]      p1_addr;
  logic               p2_vld;
  logic [AW-1:0]      p2_addr;
  logic [31:0]        p2_v;
  logic [63:0]        p2_prod;
  logic [31:0]        res_level;

  // memory ports
  logic               lvl_we;
  logic [AW-1:0]      lvl_waddr;
  logic [31:0]        lvl_wdata;
  logic [AW-1:0]      lvl_raddr;
  logic [31:0]        lvl_q;
  logic               scr_we;
  logic [AW-1:0]      scr_waddr;
  logic [31:0]        scr_wdata;
  logic [AW-1:0]      scr_raddr;
  logic [31:0]        scr_q;

  // combinational helpers
  logic [SZW-1:0]     w_eff;
  logic [SZW-1:0]     h_eff;
  logic [23:0]        x_abs;
  logic [23:0]        y_abs;
  logic [24:0]        x_rnd;
  logic [24:0]        y_rnd;
  logic [SZW:0]       div_sh;
  logic               div_ge;
  logic [SZW-1:0]     place_val;
  logic               x_lo;
  logic               x_hi;
  logic               y_lo;
  logic               y_hi;
  logic               last_cell;
  logic [1:0]         cnt_x;
  logic [1:0]         cnt_y;
  logic [3:0]         nb_n;
  logic [SZW-1:0]     nb_x;
  logic [SZW-1:0]     nb_y;
  logic               nb_ok;
  logic [AW-1:0]      cur_addr;
  logic [AW-1:0]      cell_addr;
  logic [AW-1:0]      nb_addr;
  logic [31:0]        v_abs;
  logic [39:0]        ev_e;
  logic signed [41:0] ev_se;
  logic signed [41:0] ev_nv;
  logic [31:0]        ev_res;
  logic signed [41:0] rmw_sum;
  logic               cfg_wr;

  function automatic logic [AW-1:0] addr_of(input logic [SZW-1:0] xa,
                                            input logic [SZW-1:0] ya);
    return AW'(32'(ya) * MAX_COLUMNS + 32'(xa));
  endfunction

  // effective grid size, zero acts as one and a size above the maximum as the maximum
  always_comb begin
    if (grid_width == '0) begin
      w_eff = SZW'(1);
    end else if (32'(grid_width) > MAX_COLUMNS) begin
      w_eff = SZW'(MAX_COLUMNS);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height == '0) begin
      h_eff = SZW'(1);
    end else if (32'(grid_height) > MAX_ROWS) begin
      h_eff = SZW'(MAX_ROWS);
    end else begin
      h_eff = grid_height;
    end
  end

  // coordinate rounding, half away from zero
  assign x_abs = x_pos[23] ? 24'(-x_pos) : x_pos;
  assign y_abs = y_pos[23] ? 24'(-y_pos) : y_pos;
  assign x_rnd = {1'b0, x_abs} + 25'd128;
  assign y_rnd = {1'b0, y_abs} + 25'd128;

  // divider step, one quotient bit per cycle
  assign div_sh = {div_rem, div_quo[DIVW-1]};
  assign div_ge = div_sh >= {1'b0, div_den};

  // coordinate placement from divider remainder
  assign place_val = (state == S_XFIX)
                     ? pgd_pkg::place(x_mag, x_neg, div_rem, w_eff, wrap_edges)
                     : pgd_pkg::place(y_mag, y_neg, div_rem, h_eff, wrap_edges);

  // scan position and edges
  assign x_lo      = (x_cnt == '0);
  assign x_hi      = (x_cnt == w_eff - 1'b1);
  assign y_lo      = (y_cnt == '0);
  assign y_hi      = (y_cnt == h_eff - 1'b1);
  assign last_cell = x_hi && y_hi;
  assign cur_addr  = addr_of(x_cnt, y_cnt);
  assign cell_addr = addr_of(cx, cy);

  // neighbor count at a cut edge
  assign cnt_x = 2'd1 + 2'(!x_lo) + 2'(!x_hi);
  assign cnt_y = 2'd1 + 2'(!y_lo) + 2'(!y_hi);
  assign nb_n  = wrap_edges ? 4'd8 : 4'(4'(cnt_x) * 4'(cnt_y) - 4'd1);

  // neighbor position for the current offset
  always_comb begin
    logic ok_x;
    logic ok_y;
    ok_x = 1'b1;
    ok_y = 1'b1;
    case (pgd_pkg::nb_dx(nb_cnt))
      pgd_pkg::OFF_NEG: begin
        nb_x = x_lo ? w_eff - 1'b1 : x_cnt - 1'b1;
        ok_x = !x_lo || wrap_edges;
      end
      pgd_pkg::OFF_ZERO: nb_x = x_cnt;
      default: begin
        nb_x = x_hi ? '0 : x_cnt + 1'b1;
        ok_x = !x_hi || wrap_edges;
      end
    endcase
    case (pgd_pkg::nb_dy(nb_cnt))
      pgd_pkg::OFF_NEG: begin
        nb_y = y_lo ? h_eff - 1'b1 : y_cnt - 1'b1;
        ok_y = !y_lo || wrap_edges;
      end
      pgd_pkg::OFF_ZERO: nb_y = y_cnt;
      default: begin
        nb_y = y_hi ? '0 : y_cnt + 1'b1;
        ok_y = !y_hi || wrap_edges;
      end
    endcase
    nb_ok = (nb_cnt == pgd_pkg::NB_SELF) || (ok_x && ok_y);
  end

  assign nb_addr = (nb_cnt == pgd_pkg::NB_SELF) ? cur_addr : addr_of(nb_x, nb_y);

  // evaporation result from the product stage
  assign v_abs  = lvl_q[31] ? 32'(-lvl_q) : lvl_q;
  assign ev_e   = p2_prod[63:24];
  assign ev_se  = p2_v[31] ? -$signed({2'b00, ev_e}) : $signed({2'b00, ev_e});
  assign ev_nv  = $signed({{10{p2_v[31]}}, p2_v}) - ev_se;
  assign ev_res = (ev_nv < $signed({{10{min_level[31]}}, min_level}))
                  ? '0 : pgd_pkg::sat_q(ev_nv);

  // scatter add or self subtract on the scratch entry
  assign rmw_sum = (nb_cnt == pgd_pkg::NB_SELF)
                   ? $signed({{10{scr_q[31]}}, scr_q}) - $signed({3'b000, amount})
                   : $signed({{10{scr_q[31]}}, scr_q}) + $signed({3'b000, div_quo});

  // memory port selection
  always_comb begin
    lvl_we    = 1'b0;
    lvl_waddr = p1_addr;
    lvl_wdata = scr_q;
    scr_we    = 1'b0;
    scr_waddr = p1_addr;
    scr_wdata = lvl_q;
    lvl_raddr = (state == S_CELL) ? cell_addr : cur_addr;
    scr_raddr = (state == S_NRD) ? nb_addr : cur_addr;
    if (state == S_CLEAR) begin
      lvl_we    = 1'b1;
      lvl_waddr = lin_cnt;
      lvl_wdata = '0;
    end else if (state == S_FILL) begin
      lvl_we    = 1'b1;
      lvl_waddr = lin_cnt;
      lvl_wdata = default_level;
    end else if (state == S_CELL && mode_r == pgd_pkg::MODE_WRITE) begin
      lvl_we    = 1'b1;
      lvl_waddr = cell_addr;
      lvl_wdata = lvl_in_r;
    end else if (p1_vld && sw_kind == SW_BACK) begin
      lvl_we    = 1'b1;
    end else if (p2_vld) begin
      lvl_we    = 1'b1;
      lvl_waddr = p2_addr;
      lvl_wdata = ev_res;
    end
    if (p1_vld && sw_kind == SW_COPY) begin
      scr_we = 1'b1;
    end else if (state == S_NWR) begin
      scr_we    = 1'b1;
      scr_waddr = tgt_addr;
      scr_wdata = pgd_pkg::sat_q(rmw_sum);
    end
  end

  pgd_ram #(.WIDTH(32), .DEPTH(CELLS), .AW(AW)) u_level_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wdata),
    .raddr (lvl_raddr),
    .rdata (lvl_q)
  );

  pgd_ram #(.WIDTH(32), .DEPTH(CELLS), .AW(AW)) u_scratch_ram (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .raddr (scr_raddr),
    .rdata (scr_q)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width       <= SZW'(64);
      grid_height      <= SZW'(64);
      wrap_edges       <= 1'b1;
      diffusion_coef   <= '0;
      evaporation_coef <= '0;
      min_level        <= '0;
      default_level    <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        pgd_pkg::REG_GRID_WIDTH:  grid_width       <= pwdata[SZW-1:0];
        pgd_pkg::REG_GRID_HEIGHT: grid_height      <= pwdata[SZW-1:0];
        pgd_pkg::REG_WRAP_EDGES:  wrap_edges       <= pwdata[0];
        pgd_pkg::REG_DIFF_COEF:   diffusion_coef   <= pwdata[15:0];
        pgd_pkg::REG_EVAP_COEF:   evaporation_coef <= pwdata[15:0];
        pgd_pkg::REG_MIN_LEVEL:   min_level        <= pwdata;
        pgd_pkg::REG_DEFAULT_LVL: default_level    <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[4:2])
      pgd_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width);
      pgd_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height);
      pgd_pkg::REG_WRAP_EDGES:  prdata = 32'(wrap_edges);
      pgd_pkg::REG_DIFF_COEF:   prdata = 32'(diffusion_coef);
      pgd_pkg::REG_EVAP_COEF:   prdata = 32'(evaporation_coef);
      pgd_pkg::REG_MIN_LEVEL:   prdata = min_level;
      pgd_pkg::REG_DEFAULT_LVL: prdata = default_level;
      default:                  prdata = '0;
    endcase
  end

  assign busy = (state != S_IDLE);

  // sweep pipeline, read then write from stage p1 for the copies or from stage p2 for evaporation
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
    end else begin
      p1_vld <= (state == S_SWEEP);
      p2_vld <= p1_vld && (sw_kind == SW_EVAP);
    end
    p1_addr <= cur_addr;
    p2_addr <= p1_addr;
    p2_v    <= lvl_q;
    p2_prod <= cd_evap * v_abs;
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      lin_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state) inside
        S_IDLE: begin
          if (start) begin
            mode_r    <= mode;
            lvl_in_r  <= level_in;
            dt_r      <= time_step;
            res_level <= '0;
            x_mag     <= x_rnd[24:8];
            y_mag     <= y_rnd[24:8];
            x_neg     <= x_pos[23];
            y_neg     <= y_pos[23];
            lin_cnt   <= '0;
            div_quo   <= DIVW'(x_rnd[24:8]);
            div_rem   <= '0;
            div_den   <= w_eff;
            div_cnt   <= DCW'(DIVW - 1);
            case (mode)
              pgd_pkg::MODE_FILL:  state <= S_FILL;
              pgd_pkg::MODE_TICK:  state <= S_TSTART;
              default:             state <= S_XDIV;
            endcase
          end
        end
        S_CLEAR, S_FILL: begin
          lin_cnt <= lin_cnt + 1'b1;
          if (lin_cnt == AW'(CELLS - 1)) begin
            state <= (state == S_CLEAR) ? S_IDLE : S_FINISH;
          end
        end
        S_XDIV, S_YDIV, S_DDIV: begin
          div_quo <= {div_quo[DIVW-2:0], div_ge};
          div_rem <= div_ge ? SZW'(div_sh - {1'b0, div_den}) : div_sh[SZW-1:0];
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            if (state == S_XDIV) begin
              state <= S_XFIX;
            end else if (state == S_YDIV) begin
              state <= S_YFIX;
            end else begin
              nb_cnt <= '0;
              state  <= S_NRD;
            end
          end
        end
        S_XFIX: begin
          cx      <= place_val;
          div_quo <= DIVW'(y_mag);
          div_rem <= '0;
          div_den <= h_eff;
          div_cnt <= DCW'(DIVW - 1);
          state   <= S_YDIV;
        end
        S_YFIX: begin
          cy    <= place_val;
          state <= S_CELL;
        end
        S_CELL: begin
          state <= (mode_r == pgd_pkg::MODE_WRITE) ? S_FINISH : S_CDATA;
        end
        S_CDATA: begin
          res_level <= lvl_q;
          state     <= S_FINISH;
        end
        S_TSTART: begin
          cd_diff <= diffusion_coef * dt_r;
          cd_evap <= evaporation_coef * dt_r;
          x_cnt   <= '0;
          y_cnt   <= '0;
          if (diffusion_coef != '0) begin
            sw_kind <= SW_COPY;
            state   <= S_SWEEP;
          end else if (evaporation_coef != '0) begin
            sw_kind <= SW_EVAP;
            state   <= S_SWEEP;
          end else begin
            state <= S_FINISH;
          end
        end
        S_SWEEP: begin
          if (last_cell) begin
            drain_cnt <= 1'b1;
            state     <= S_DRAIN;
          end else if (x_hi) begin
            x_cnt <= '0;
            y_cnt <= y_cnt + 1'b1;
          end else begin
            x_cnt <= x_cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          drain_cnt <= 1'b0;
          if (!drain_cnt) begin
            x_cnt <= '0;
            y_cnt <= '0;
            if (sw_kind == SW_COPY) begin
              state <= S_DRD;
            end else if (sw_kind == SW_BACK && evaporation_coef != '0) begin
              sw_kind <= SW_EVAP;
              state   <= S_SWEEP;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_DRD: begin
          state <= S_DDATA;
        end
        S_DDATA: begin
          dprod   <= cd_diff * lvl_q;
          div_den <= SZW'(nb_n);
          if (!lvl_q[31] && lvl_q != '0 && nb_n != '0) begin
            state <= S_DAMT;
          end else if (last_cell) begin
            x_cnt   <= '0;
            y_cnt   <= '0;
            sw_kind <= SW_BACK;
            state   <= S_SWEEP;
          end else begin
            if (x_hi) begin
              x_cnt <= '0;
              y_cnt <= y_cnt + 1'b1;
            end else begin
              x_cnt <= x_cnt + 1'b1;
            end
            state <= S_DRD;
          end
        end
        S_DAMT: begin
          amount  <= dprod[62:24];
          div_quo <= dprod[62:24];
          div_rem <= '0;
          div_cnt <= DCW'(DIVW - 1);
          state   <= S_DDIV;
        end
        S_NRD: begin
          tgt_addr <= nb_addr;
          if (nb_ok) begin
            state <= S_NWR;
          end else begin
            nb_cnt <= nb_cnt + 1'b1;
          end
        end
        S_NWR: begin
          if (nb_cnt != pgd_pkg::NB_SELF) begin
            nb_cnt <= nb_cnt + 1'b1;
            state  <= S_NRD;
          end else if (last_cell) begin
            x_cnt   <= '0;
            y_cnt   <= '0;
            sw_kind <= SW_BACK;
            state   <= S_SWEEP;
          end else begin
            if (x_hi) begin
              x_cnt <= '0;
              y_cnt <= y_cnt + 1'b1;
            end else begin
              x_cnt <= x_cnt + 1'b1;
            end
            state <= S_DRD;
          end
        end
        S_FINISH: begin
          done      <= 1'b1;
          level_out <= res_level;
          done_mode <= mode_r;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result is given only as the unit returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // one result per request, never two in a row
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // an accepted request keeps the unit busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but unit not busy");

  // the shared divider never divides by zero
  a_div_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_XDIV || state == S_YDIV || state == S_DDIV) |-> div_den != '0)
    else $error("divider started with zero divisor");
`endif

endmodule

### hdl/pgd_ram.sv
// ----------------------------------------------------------------------------
// pgd_ram
// Simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the pheromone grid unit against an in-bench grid predictor: fill,
// cell write and read with coordinate rounding, wrap and clamp, and ticks of
// diffusion and evaporation, over several grid settings, with random gaps.
// ----------------------------------------------------------------------------
module tb;

  localparam int COLS  = pgd_pkg::DEFAULT_MAX_COLUMNS;
  localparam int ROWS  = pgd_pkg::DEFAULT_MAX_ROWS;
  localparam int CELLS = COLS * ROWS;

  typedef struct {
    logic [1:0]         mode;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [31:0] lvl;
    logic [15:0]        dt;
  } grid_req_t;

  typedef struct {
    logic signed [31:0] lvl;
    logic [1:0]         mode;
  } grid_res_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               mode = pgd_pkg::MODE_FILL;
  logic signed [23:0]       x_pos = '0;
  logic signed [23:0]       y_pos = '0;
  logic signed [31:0]       level_in = '0;
  logic [15:0]              time_step = '0;
  logic                     done;
  logic signed [31:0]       level_out;
  logic [1:0]               done_mode;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [pgd_pkg::PAW-1:0]  paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  pheromone_grid_diffusion_unit dut (.*);

  // pending requests and expected results
  grid_req_t req_q[$];
  grid_res_t result_q[$];
  int        errs = 0;
  bit        took = 1'b0;
  bit        no_gaps = 1'b0;

  // predictor state
  int        cells[CELLS];
  int        scratch[CELLS];
  int        cfg_w = 64;
  int        cfg_h = 64;
  bit        cfg_wrap = 1'b1;
  int        cfg_dc = 0;
  int        cfg_ec = 0;
  int        cfg_min = 0;
  int        cfg_dflt = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    errs++;
    if (errs <= 20) begin
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    end
  endtask

  function automatic int sat(input longint s);
    int r;
    if (s > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (s < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = int'(s);
    end
    return r;
  endfunction

  function automatic int eff(input int v);
    int r;
    r = (v < 1) ? 1 : (v > 64) ? 64 : v;
    return r;
  endfunction

  function automatic int to_cell(input logic signed [23:0] c, input int size);
    longint v;
    int r;
    v = c;
    r = (v >= 0) ? int'((v + 128) >>> 8) : -int'(((-v) + 128) >>> 8);
    if (cfg_wrap) begin
      r = ((r % size) + size) % size;
    end else if (r < 0) begin
      r = 0;
    end else if (r > size - 1) begin
      r = size - 1;
    end
    return r;
  endfunction

  function automatic longint scale(input longint unsigned mag, input int coef,
                                   input logic [15:0] dt);
    longint unsigned p;
    p = mag * longint'(unsigned'(coef)) * longint'(dt);
    return longint'(p >> 24);
  endfunction

  // one tick: diffusion into scratch, then evaporation
  task automatic run_tick(input logic [15:0] dt, input int w, input int h);
    int n, nx, ny, k;
    longint amount, share, v, e, nv;
    if (cfg_dc != 0) begin
      scratch = cells;
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          if (cells[y*COLS+x] > 0) begin
            n = 0;
            for (int dy = -1; dy <= 1; dy++) begin
              for (int dx = -1; dx <= 1; dx++) begin
                nx = x + dx;
                ny = y + dy;
                if ((dx != 0 || dy != 0) &&
                    (cfg_wrap || (nx >= 0 && nx < w && ny >= 0 && ny < h))) begin
                  n++;
                end
              end
            end
            if (n != 0) begin
              amount = scale(cells[y*COLS+x], cfg_dc, dt);
              share = amount / n;
              for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                  nx = x + dx;
                  ny = y + dy;
                  if (cfg_wrap) begin
                    nx = ((nx % w) + w) % w;
                    ny = ((ny % h) + h) % h;
                  end
                  if ((dx != 0 || dy != 0) && nx >= 0 && nx < w && ny >= 0 && ny < h) begin
                    k = ny * COLS + nx;
                    scratch[k] = sat(longint'(scratch[k]) + share);
                  end
                end
              end
              k = y * COLS + x;
              scratch[k] = sat(longint'(scratch[k]) - amount);
            end
          end
        end
      end
      cells = scratch;
    end
    if (cfg_ec != 0) begin
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          k = y * COLS + x;
          v = cells[k];
          e = (v >= 0) ? scale(v, cfg_ec, dt) : -scale(-v, cfg_ec, dt);
          nv = v - e;
          cells[k] = (nv < longint'(cfg_min)) ? 0 : sat(nv);
        end
      end
    end
  endtask

  // apply one accepted request to the predicted grid
  task automatic predict_grid(input grid_req_t r, output grid_res_t res);
    int w, h, k;
    w = eff(cfg_w);
    h = eff(cfg_h);
    res.lvl = '0;
    res.mode = r.mode;
    case (r.mode) inside
      pgd_pkg::MODE_FILL: begin
        foreach (cells[i]) cells[i] = cfg_dflt;
      end
      pgd_pkg::MODE_WRITE, pgd_pkg::MODE_READ: begin
        k = to_cell(r.y, h) * COLS + to_cell(r.x, w);
        if (r.mode == pgd_pkg::MODE_WRITE) cells[k] = r.lvl;
        else res.lvl = cells[k];
      end
      default: begin
        run_tick(r.dt, w, h);
      end
    endcase
  endtask

  // monitor: check results, then predict newly accepted requests
  always @(posedge clk) begin
    grid_req_t r;
    grid_res_t want, exp_res;
    if (rst) begin
      took = 1'b0;
    end else begin
      if (done) begin
        if (result_q.size() == 0) begin
          report("unexpected result", level_out, 0);
        end else begin
          exp_res = result_q.pop_front();
          if (level_out !== exp_res.lvl) report("level_out", level_out, exp_res.lvl);
          if (done_mode !== exp_res.mode) report("done_mode", done_mode, exp_res.mode);
        end
      end
      took = start && !busy;
      if (took) begin
        r.mode = mode;
        r.x = x_pos;
        r.y = y_pos;
        r.lvl = level_in;
        r.dt = time_step;
        predict_grid(r, want);
        result_q.insert(result_q.size(), want);
      end
    end
  end

  // driver: present the next request once the current one is taken
  always @(negedge clk) begin
    grid_req_t r;
    if (!rst && (!start || took)) begin
      if (req_q.size() != 0 && (no_gaps || $urandom_range(99) >= 27)) begin
        r = req_q.pop_front();
        mode <= r.mode;
        x_pos <= r.x;
        y_pos <= r.y;
        level_in <= r.lvl;
        time_step <= r.dt;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      pgd_pkg::REG_GRID_WIDTH:  cfg_w = val[6:0];
      pgd_pkg::REG_GRID_HEIGHT: cfg_h = val[6:0];
      pgd_pkg::REG_WRAP_EDGES:  cfg_wrap = val[0];
      pgd_pkg::REG_DIFF_COEF:   cfg_dc = val[15:0];
      pgd_pkg::REG_EVAP_COEF:   cfg_ec = val[15:0];
      pgd_pkg::REG_MIN_LEVEL:   cfg_min = val;
      default:                  cfg_dflt = val;
    endcase
  endtask

  task automatic set_grid(input int w, input int h, input bit wrap, input int dc,
                          input int ec, input int mn, input int dflt);
    cfg_write(pgd_pkg::REG_GRID_WIDTH, w);
    cfg_write(pgd_pkg::REG_GRID_HEIGHT, h);
    cfg_write(pgd_pkg::REG_WRAP_EDGES, 32'(wrap));
    cfg_write(pgd_pkg::REG_DIFF_COEF, dc);
    cfg_write(pgd_pkg::REG_EVAP_COEF, ec);
    cfg_write(pgd_pkg::REG_MIN_LEVEL, mn);
    cfg_write(pgd_pkg::REG_DEFAULT_LVL, dflt);
  endtask

  task automatic add_req(input logic [1:0] m, input logic signed [23:0] x,
                         input logic signed [23:0] y, input logic signed [31:0] lvl,
                         input logic [15:0] dt);
    grid_req_t r;
    r.mode = m;
    r.x = x;
    r.y = y;
    r.lvl = lvl;
    r.dt = dt;
    req_q.insert(req_q.size(), r);
  endtask

  function automatic logic [23:0] rand_coord(input int size);
    logic [23:0] c;
    if ($urandom_range(3) == 0) begin
      c = 24'($urandom);
    end else begin
      c = 24'($urandom_range(0, 4 * size * 256) - 2 * size * 256);
      if ($urandom_range(3) == 0) c[7:0] = 8'h80;
    end
    return c;
  endfunction

  function automatic logic [31:0] rand_level();
    logic [31:0] v;
    case ($urandom_range(3)) inside
      0, 1:    v = $urandom_range(0, 32'h0040_0000);
      2:       v = $urandom;
      default: v = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
    return v;
  endfunction

  // random requests: mostly writes and reads, some ticks, rare fills
  task automatic add_random(input int count);
    int w, h, pick;
    logic [1:0] m;
    logic [15:0] dt;
    w = eff(cfg_w);
    h = eff(cfg_h);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      m = (pick < 5) ? pgd_pkg::MODE_FILL : (pick < 40) ? pgd_pkg::MODE_WRITE
        : (pick < 75) ? pgd_pkg::MODE_READ : pgd_pkg::MODE_TICK;
      dt = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 16'h0200));
      add_req(m, rand_coord(w), rand_coord(h), rand_level(), dt);
    end
  endtask

  task automatic drain();
    while (req_q.size() != 0 || start || result_q.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // coordinate extremes, rounding halves and level extremes on the reset grid
    add_req(pgd_pkg::MODE_READ, 24'sd0, 24'sd0, 32'sd0, 16'd0);
    add_req(pgd_pkg::MODE_WRITE, 24'h7fffff, 24'h800000, 32'h7fff_ffff, 16'hffff);
    add_req(pgd_pkg::MODE_READ, 24'h7fffff, 24'h800000, 32'sd0, 16'd0);
    add_req(pgd_pkg::MODE_WRITE, 24'h000080, 24'hffff80, 32'h8000_0000, 16'd0);
    add_req(pgd_pkg::MODE_READ, 24'h000100, 24'h003f00, 32'sd0, 16'd0);
    add_req(pgd_pkg::MODE_WRITE, 24'h00007f, 24'hffff81, 32'h1234_5678, 16'd0);
    add_req(pgd_pkg::MODE_READ, 24'sd0, 24'sd0, 32'sd0, 16'd0);
    add_req(pgd_pkg::MODE_TICK, 24'sd0, 24'sd0, 32'sd0, 16'hffff);
    add_req(pgd_pkg::MODE_READ, 24'h000080, 24'hffff80, 32'sd0, 16'd0);
    add_req(pgd_pkg::MODE_FILL, 24'sd0, 24'sd0, 32'sd0, 16'd0);
    add_req(pgd_pkg::MODE_READ, 24'h7fffff, 24'h800000, 32'sd0, 16'd0);
    drain();

    // one cell without wrap: clamping, no diffusion, extreme thresholds
    set_grid(1, 1, 1'b0, 16'hffff, 16'hffff, 32'h8000_0000, 32'h7fff_ffff);
    add_req(pgd_pkg::MODE_FILL, 24'sd0, 24'sd0, 32'sd0, 16'd0);
    add_req(pgd_pkg::MODE_TICK, 24'sd0, 24'sd0, 32'sd0, 16'h0100);
    add_req(pgd_pkg::MODE_READ, 24'h7fffff, 24'h800000, 32'sd0, 16'd0);
    add_req(pgd_pkg::MODE_WRITE, 24'sd0, 24'sd0, 32'hffff_0000, 16'd0);
    add_req(pgd_pkg::MODE_TICK, 24'sd0, 24'sd0, 32'sd0, 16'hffff);
    add_req(pgd_pkg::MODE_READ, 24'sd0, 24'sd0, 32'sd0, 16'd0);
    add_random(6);
    drain();

    // tiny torus with no gaps on the request side
    no_gaps = 1'b1;
    set_grid(3, 2, 1'b1, 16'h8000, 16'h1000, 0, 32'h0001_0000);
    add_req(pgd_pkg::MODE_FILL, 24'sd0, 24'sd0, 32'sd0, 16'd0);
    add_req(pgd_pkg::MODE_TICK, 24'sd0, 24'sd0, 32'sd0, 16'h0100);
    add_random(15);
    drain();
    no_gaps = 1'b0;

    // cut edges, top threshold
    set_grid(5, 4, 1'b0, $urandom_range(1, 16'hffff), $urandom_range(1, 16'hffff),
             32'h7fff_ffff, 32'h0000_8000);
    add_random(20);
    drain();

    // widths out of range act as one and as the maximum
    set_grid(0, 100, 1'b1, 16'h0400, 0, -32'sd65536, 32'hfff0_0000);
    add_random(15);
    drain();

    // random small settings
    for (int p = 0; p < 3; p++) begin
      set_grid($urandom_range(1, 8), $urandom_range(1, 8), 1'($urandom_range(1)),
               $urandom_range(0, 16'hffff), $urandom_range(0, 16'hffff),
               -int'($urandom_range(0, 32'h0010_0000)), $urandom);
      add_random(8);
      drain();
    end

    // full grid, one heavy tick
    set_grid(64, 64, 1'b1, 16'hffff, 16'h0001, 0, 32'h0003_0000);
    add_req(pgd_pkg::MODE_FILL, 24'sd0, 24'sd0, 32'sd0, 16'd0);
    add_req(pgd_pkg::MODE_WRITE, 24'h001000, 24'h001000, 32'h7fff_ffff, 16'd0);
    add_req(pgd_pkg::MODE_TICK, 24'sd0, 24'sd0, 32'sd0, 16'h0180);
    add_req(pgd_pkg::MODE_READ, 24'h001000, 24'h001000, 32'sd0, 16'd0);
    add_req(pgd_pkg::MODE_READ, 24'h003f00, 24'h000f00, 32'sd0, 16'd0);
    add_req(pgd_pkg::MODE_READ, 24'h000f00, 24'h000f00, 32'sd0, 16'd0);
    drain();

    repeat (100) @(posedge clk);
    if (errs == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
